// ===== rtl/core/glyph_bitmap_to_gray_expander_unit_assert.svh =====
// Assertion macros used by the expander RTL.
`ifndef GLYPH_BITMAP_TO_GRAY_EXPANDER_UNIT_ASSERT_SVH
`define GLYPH_BITMAP_TO_GRAY_EXPANDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GBG_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbg: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GBG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbg: next-cycle check failed");

`endif

// ===== rtl/core/gbg_pkg.sv =====
package gbg_pkg;

  localparam int MAX_WIDTH = 1023;
  localparam int MAX_ROWS  = 1023;
  localparam int MAX_PITCH = 2047;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;

  localparam logic [CFG_IW-1:0] REG_PIXEL_MODE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WIDTH      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ROWS       = 3'd2;
  localparam logic [CFG_IW-1:0] REG_PITCH      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CAPACITY   = 3'd4;

  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_MONO = 2'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TOO_SMALL   = 2'd3
  } status_t;

  typedef struct packed {
    status_t      status;
    logic [19:0]  required;
    logic         run_ok;
    logic         mono;
    logic [11:0]  pitch_mag;
    logic [10:0]  row_bytes;
  } start_res_t;

endpackage

// ===== rtl/core/gbg_start_check.sv =====
module gbg_start_check (
  input  logic [1:0]          pixel_mode,
  input  logic [9:0]          glyph_width,
  input  logic [9:0]          glyph_rows,
  input  logic signed [11:0]  row_pitch,
  input  logic [19:0]         output_capacity,
  output gbg_pkg::start_res_t res
);
  import gbg_pkg::*;

  logic [19:0] required;
  logic [11:0] mag;
  logic [10:0] row_bytes;
  logic [10:0] width_up;
  logic        bad_arg;

  assign required = 20'(glyph_width) * 20'(glyph_rows);
  assign mag      = row_pitch[11] ? 12'(-row_pitch) : 12'(row_pitch);
  assign width_up = 11'(glyph_width) + 11'd7;
  assign row_bytes = (pixel_mode == MODE_MONO) ? 11'(width_up[10:3]) : 11'(glyph_width);

  assign bad_arg = ((glyph_rows != 10'd0) && (mag < 12'(row_bytes))) ||
                   (32'(glyph_width) > MAX_WIDTH) ||
                   (32'(glyph_rows) > MAX_ROWS) ||
                   (32'(mag) > MAX_PITCH);

  always_comb begin
    res.required  = required;
    res.mono      = (pixel_mode == MODE_MONO);
    res.pitch_mag = mag;
    res.row_bytes = row_bytes;
    res.run_ok    = 1'b0;
    if ((pixel_mode != MODE_GRAY) && (pixel_mode != MODE_MONO)) begin
      res.status = ST_UNSUPPORTED;
    end else if (bad_arg) begin
      res.status = ST_INVALID;
    end else if (required == 20'd0) begin
      res.status = ST_OK;
    end else if (output_capacity < required) begin
      res.status = ST_TOO_SMALL;
    end else begin
      res.status = ST_OK;
      res.run_ok = 1'b1;
    end
  end

endmodule

// ===== rtl/core/glyph_bitmap_to_gray_expander_unit.sv =====
// Glyph bitmap expander: a start beat (in_tuser 0) checks the configured glyph and returns
// one status beat carrying width*rows; after an ok start, data beats (in_tuser 1) bring the
// source bytes row by row, |row_pitch| bytes per row, and each used byte becomes one gray
// pixel beat (gray mode) or up to eight 255/0 pixel beats, MSB first (mono mode); padding
// bytes and data beats while idle give no output. Start and gray data beats run at one beat
// per cycle while the output is not stalled; a mono byte stays in the pixel stage until
// all of its pixels, up to eight, are sent, because the single output register sends one
// pixel per cycle. An accepted beat passes through the input register, the pixel stage and
// the output register. Configuration writes are taken at once and apply at the next start.
`include "glyph_bitmap_to_gray_expander_unit_assert.svh"

module glyph_bitmap_to_gray_expander_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] source_byte
  input  logic                        in_tuser,   // [0] operation
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [55:0]                 out_tdata,  // [1:0] status_code, [21:2] required_bytes,
                                                  // [29:22] pixel_value, [49:30] pixel_index
  output logic                        out_tuser,  // [0] result_kind
  output logic                        out_tlast,  // last
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gbg_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [gbg_pkg::CFG_DW-1:0]  cfg_data
);
  import gbg_pkg::*;

  // configuration
  logic [1:0]         pixel_mode_r;
  logic [9:0]         glyph_width_r;
  logic [9:0]         glyph_rows_r;
  logic signed [11:0] row_pitch_r;
  logic [19:0]        output_capacity_r;

  // input stage
  logic       in_vld_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;

  // run state
  logic        busy_r, busy_nxt;
  logic [9:0]  cur_row_r, cur_row_nxt;
  logic [10:0] bir_r, bir_nxt;
  logic [19:0] next_pix_r, next_pix_nxt;
  logic        run_mono_r;
  logic [9:0]  run_width_r;
  logic [9:0]  run_rows_r;
  logic [11:0] run_mag_r;
  logic [10:0] run_row_bytes_r;

  // pixel stage
  logic        pend_kind_r, pend_kind_nxt;
  status_t     pend_status_r, pend_status_nxt;
  logic [19:0] pend_req_r, pend_req_nxt;
  logic [7:0]  pend_bits_r, pend_bits_nxt;
  logic        pend_mono_r, pend_mono_nxt;
  logic [19:0] pend_idx_r, pend_idx_nxt;
  logic [3:0]  pend_cnt_r, pend_cnt_nxt;

  // output stage
  logic        out_vld_r;
  logic        out_kind_r;
  status_t     out_status_r;
  logic [19:0] out_req_r;
  logic [7:0]  out_val_r;
  logic [19:0] out_idx_r;
  logic        out_last_r;

  start_res_t  chk;
  logic        out_load, emit, take;
  logic [11:0] bir_inc;
  logic [10:0] row_inc;
  logic [13:0] col, rem;
  logic [3:0]  mono_n;

  gbg_start_check u_check (
    .pixel_mode      (pixel_mode_r),
    .glyph_width     (glyph_width_r),
    .glyph_rows      (glyph_rows_r),
    .row_pitch       (row_pitch_r),
    .output_capacity (output_capacity_r),
    .res             (chk)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r      <= MODE_GRAY;
      glyph_width_r     <= '0;
      glyph_rows_r      <= '0;
      row_pitch_r       <= '0;
      output_capacity_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PIXEL_MODE: pixel_mode_r      <= cfg_data[1:0];
        REG_WIDTH:      glyph_width_r     <= cfg_data[9:0];
        REG_ROWS:       glyph_rows_r      <= cfg_data[9:0];
        REG_PITCH:      row_pitch_r       <= cfg_data[11:0];
        REG_CAPACITY:   output_capacity_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign out_load  = !out_vld_r || out_tready;
  assign emit      = (pend_cnt_r != 4'd0) && out_load;
  assign take      = in_vld_r && ((pend_cnt_r == 4'd0) || ((pend_cnt_r == 4'd1) && out_load));
  assign in_tready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  assign bir_inc = 12'(bir_r) + 12'd1;
  assign row_inc = 11'(cur_row_r) + 11'd1;
  assign col     = {bir_r, 3'b000};
  assign rem     = 14'(run_width_r) - col;
  assign mono_n  = (rem >= 14'd8) ? 4'd8 : rem[3:0];

  always_comb begin
    busy_nxt        = busy_r;
    cur_row_nxt     = cur_row_r;
    bir_nxt         = bir_r;
    next_pix_nxt    = next_pix_r;
    pend_kind_nxt   = pend_kind_r;
    pend_status_nxt = pend_status_r;
    pend_req_nxt    = pend_req_r;
    pend_bits_nxt   = pend_bits_r;
    pend_mono_nxt   = pend_mono_r;
    pend_idx_nxt    = pend_idx_r;
    pend_cnt_nxt    = pend_cnt_r;
    if (emit) begin
      pend_cnt_nxt  = pend_cnt_r - 4'd1;
      pend_bits_nxt = {pend_bits_r[6:0], 1'b0};
      pend_idx_nxt  = pend_idx_r + 20'd1;
    end
    if (take) begin
      pend_cnt_nxt = 4'd0;
      if (in_op_r == OP_START) begin
        busy_nxt        = chk.run_ok;
        pend_kind_nxt   = KIND_STATUS;
        pend_status_nxt = chk.status;
        pend_req_nxt    = chk.required;
        pend_cnt_nxt    = 4'd1;
        if (chk.run_ok) begin
          cur_row_nxt  = '0;
          bir_nxt      = '0;
          next_pix_nxt = '0;
        end
      end else if (busy_r) begin
        pend_kind_nxt = KIND_PIXEL;
        pend_bits_nxt = in_byte_r;
        pend_mono_nxt = run_mono_r;
        pend_idx_nxt  = next_pix_r;
        if (bir_r < run_row_bytes_r) begin
          if (run_mono_r) begin
            pend_cnt_nxt = mono_n;
            next_pix_nxt = next_pix_r + 20'(mono_n);
          end else begin
            pend_cnt_nxt = 4'd1;
            next_pix_nxt = next_pix_r + 20'd1;
          end
        end
        if (bir_inc >= run_mag_r) begin
          bir_nxt = '0;
          if (row_inc >= 11'(run_rows_r)) begin
            busy_nxt    = 1'b0;
            cur_row_nxt = '0;
          end else begin
            cur_row_nxt = row_inc[9:0];
          end
        end else begin
          bir_nxt = bir_inc[10:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cur_row_r  <= '0;
      bir_r      <= '0;
      next_pix_r <= '0;
      pend_cnt_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      cur_row_r  <= cur_row_nxt;
      bir_r      <= bir_nxt;
      next_pix_r <= next_pix_nxt;
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r   <= pend_kind_nxt;
    pend_status_r <= pend_status_nxt;
    pend_req_r    <= pend_req_nxt;
    pend_bits_r   <= pend_bits_nxt;
    pend_mono_r   <= pend_mono_nxt;
    pend_idx_r    <= pend_idx_nxt;
    if (take && (in_op_r == OP_START) && chk.run_ok) begin
      run_mono_r      <= chk.mono;
      run_width_r     <= glyph_width_r;
      run_rows_r      <= glyph_rows_r;
      run_mag_r       <= chk.pitch_mag;
      run_row_bytes_r <= chk.row_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= pend_kind_r;
      out_last_r <= (pend_cnt_r == 4'd1);
      if (pend_kind_r == KIND_STATUS) begin
        out_status_r <= pend_status_r;
        out_req_r    <= pend_req_r;
        out_val_r    <= '0;
        out_idx_r    <= '0;
      end else begin
        out_status_r <= ST_OK;
        out_req_r    <= '0;
        out_val_r    <= pend_mono_r ? {8{pend_bits_r[7]}} : pend_bits_r;
        out_idx_r    <= pend_idx_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b000000, out_idx_r, out_val_r, out_req_r, out_status_r};

  `GBG_ASSERT_NOW(a_cnt_range, 1'b1, pend_cnt_r <= 4'd8)
  `GBG_ASSERT_NOW(a_status_last, out_vld_r && (out_kind_r == KIND_STATUS), out_last_r)
  `GBG_ASSERT_NOW(a_busy_pos, busy_r, (bir_r < 11'(run_mag_r)) || (run_mag_r[11] == 1'b1))
  `GBG_ASSERT_NEXT(a_drain, emit && (pend_cnt_r == 4'd1) && !take, pend_cnt_r == 4'd0)

endmodule

// ===== bench/glyph_bitmap_to_gray_expander_unit_test.sv =====
module glyph_bitmap_to_gray_expander_unit_test;
  import gbg_pkg::*;

  localparam int LIMIT = 300000;
  localparam logic [CFG_IW-1:0] REG_SPARE = 3'd7;
  localparam logic [1:0] MODE_RSVD2 = 2'd2;
  localparam logic [1:0] MODE_RSVD3 = 2'd3;

  typedef struct {
    logic        kind;
    status_t     status;
    logic [19:0] required;
    logic [7:0]  value;
    logic [19:0] index;
    logic        last;
  } pixel_beat_t;

  class gray_expander_shadow;
    logic [1:0]         mode;
    logic [9:0]         width;
    logic [9:0]         rows;
    logic signed [11:0] pitch;
    logic [19:0]        capacity;

    bit          active;
    int unsigned cur_row;
    int unsigned col_byte;
    int unsigned pix_pos;
    bit          run_mono;
    int unsigned run_width;
    int unsigned run_rows;
    int unsigned run_span;
    int unsigned run_used;

    pixel_beat_t pending_beats[$];
    int          mismatches;

    function new();
      mode = MODE_GRAY;
      width = '0;
      rows = '0;
      pitch = '0;
      capacity = '0;
      active = 0;
      cur_row = 0;
      col_byte = 0;
      pix_pos = 0;
      run_mono = 0;
      run_width = 0;
      run_rows = 0;
      run_span = 0;
      run_used = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_PIXEL_MODE: mode = val[1:0];
        REG_WIDTH:      width = val[9:0];
        REG_ROWS:       rows = val[9:0];
        REG_PITCH:      pitch = val[11:0];
        REG_CAPACITY:   capacity = val[19:0];
        default: ;
      endcase
    endfunction

    function void push_beat(logic kind, status_t st, int unsigned req,
                            logic [7:0] val, int unsigned idx, logic last);
      pixel_beat_t b;
      b.kind = kind;
      b.status = st;
      b.required = req[19:0];
      b.value = val;
      b.index = idx[19:0];
      b.last = last;
      pending_beats.push_back(b);
    endfunction

    function void start_check();
      int          p;
      int unsigned need;
      int unsigned mag;
      int unsigned used;
      status_t     st;
      need = width * rows;
      p = pitch;
      mag = (p < 0) ? -p : p;
      active = 0;
      if (mode != MODE_GRAY && mode != MODE_MONO) begin
        push_beat(KIND_STATUS, ST_UNSUPPORTED, need, 8'h00, 0, 1'b1);
        return;
      end
      used = (mode == MODE_MONO) ? (width + 7) / 8 : width;
      if ((rows > 0 && mag < used) || width > MAX_WIDTH || rows > MAX_ROWS ||
          mag > MAX_PITCH) begin
        st = ST_INVALID;
      end else if (need == 0) begin
        st = ST_OK;
      end else if (capacity < need) begin
        st = ST_TOO_SMALL;
      end else begin
        st = ST_OK;
        active = 1;
        run_mono = (mode == MODE_MONO);
        run_width = width;
        run_rows = rows;
        run_span = mag;
        run_used = used;
        cur_row = 0;
        col_byte = 0;
        pix_pos = 0;
      end
      push_beat(KIND_STATUS, st, need, 8'h00, 0, 1'b1);
    endfunction

    function void expand_byte(logic [7:0] b);
      int unsigned col;
      int unsigned npix;
      if (!active) return;
      if (col_byte < run_used) begin
        if (!run_mono) begin
          push_beat(KIND_PIXEL, ST_OK, 0, b, pix_pos, 1'b1);
          pix_pos++;
        end else begin
          col = col_byte * 8;
          npix = (run_width - col < 8) ? run_width - col : 8;
          for (int k = 0; k < npix; k++) begin
            push_beat(KIND_PIXEL, ST_OK, 0, b[7-k] ? 8'hFF : 8'h00, pix_pos,
                      k == npix - 1);
            pix_pos++;
          end
        end
      end
      col_byte++;
      if (col_byte >= run_span) begin
        col_byte = 0;
        cur_row++;
        if (cur_row >= run_rows) begin
          active = 0;
          cur_row = 0;
        end
      end
    endfunction

    function void note_input(logic op, logic [7:0] b);
      if (op == OP_START) start_check();
      else expand_byte(b);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_beat(logic kind, logic [55:0] data, logic last);
      pixel_beat_t w;
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d data=%h", kind, data));
        return;
      end
      w = pending_beats.pop_front();
      if (kind !== w.kind)
        report($sformatf("kind %0d, want %0d", kind, w.kind));
      if (data[1:0] !== w.status)
        report($sformatf("status %0d, want %0d", data[1:0], w.status));
      if (data[21:2] !== w.required)
        report($sformatf("required %0d, want %0d", data[21:2], w.required));
      if (data[29:22] !== w.value)
        report($sformatf("pixel %0d, want %0d (index %0d)", data[29:22], w.value, w.index));
      if (data[49:30] !== w.index)
        report($sformatf("index %0d, want %0d", data[49:30], w.index));
      if (last !== w.last)
        report($sformatf("last %0d, want %0d (index %0d)", last, w.last, w.index));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [55:0]       out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  gray_expander_shadow sb;
  bit steady;
  int fed;
  int cycles;

  glyph_bitmap_to_gray_expander_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 29);
  endfunction

  always @(posedge clk) begin
    out_tready <= !take_break();
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tuser, out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] b);
    if (take_break()) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (take_break());
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, b);
    fed++;
  endtask

  task automatic feed(input int n);
    for (int i = 0; i < n; i++) send_beat(OP_DATA, 8'($urandom));
  endtask

  // hold input low until every pending pixel is out, then let padding bytes retire
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_beats.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input int w, input int r,
                           input int p, input int cap);
    logic [CFG_IW-1:0] idx [6];
    logic [CFG_DW-1:0] val [6];
    idx = '{REG_PIXEL_MODE, REG_WIDTH, REG_ROWS, REG_PITCH, REG_CAPACITY, REG_SPARE};
    val = '{20'(mode), 20'(w), 20'(r), 20'(p[11:0]), 20'(cap), 20'($urandom)};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_glyph();
    logic [1:0] mode;
    int w;
    int r;
    int used;
    int mag;
    int need;
    int cap;
    if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 1) ? MODE_RSVD3 : MODE_RSVD2;
    else mode = $urandom_range(0, 1) ? MODE_MONO : MODE_GRAY;
    w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
    r = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
    used = (mode == MODE_MONO) ? (w + 7) / 8 : w;
    mag = used + $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0 && used > 0) mag = $urandom_range(0, used - 1);
    need = w * r;
    case ($urandom_range(0, 9))
      0: cap = (need > 0) ? need - 1 : 0;
      1: cap = $urandom_range(0, 20'hFFFFF);
      default: cap = need + $urandom_range(0, 5);
    endcase
    configure(mode, w, r, $urandom_range(0, 1) ? -mag : mag, cap);
  endtask

  initial begin
    int total;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_START;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PIXEL_MODE;
    cfg_data = '0;
    steady = 0;
    fed = 0;
    cycles = 0;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty glyph is ok, data while idle is dropped
    send_beat(OP_START, 8'hFF);
    send_beat(OP_DATA, 8'hFF);

    configure(MODE_RSVD2, 5, 5, 5, 100);
    send_beat(OP_START, 8'h00);
    configure(MODE_RSVD3, 1023, 1023, 2047, 20'hFFFFF);
    send_beat(OP_START, 8'h00);
    // pitch magnitude past the maximum
    configure(MODE_GRAY, 1023, 1023, -2048, 20'hFFFFF);
    send_beat(OP_START, 8'h00);

    // largest glyph, fed briefly then abandoned by the next start
    configure(MODE_MONO, 1023, 1023, 2047, 20'hFFFFF);
    send_beat(OP_START, 8'h00);
    send_beat(OP_DATA, 8'hFF);
    send_beat(OP_DATA, 8'h00);
    send_beat(OP_DATA, 8'hA5);
    configure(MODE_GRAY, 3, 2, 2, 100);
    send_beat(OP_START, 8'h00);

    // zero rows: short pitch is fine, nothing to do
    configure(MODE_GRAY, 3, 0, 0, 0);
    send_beat(OP_START, 8'h00);

    configure(MODE_GRAY, 2, 2, -3, 3);
    send_beat(OP_START, 8'h00);
    configure(MODE_GRAY, 2, 2, -3, 4);
    send_beat(OP_START, 8'h00);
    feed(6);
    send_beat(OP_DATA, 8'h5A);

    // mono with a partial last byte; settings change mid-run
    configure(MODE_MONO, 10, 2, 2, 20);
    send_beat(OP_START, 8'h00);
    send_beat(OP_DATA, 8'h81);
    send_beat(OP_DATA, 8'hC0);
    configure(MODE_RSVD3, 0, 0, 0, 0);
    send_beat(OP_DATA, 8'h7E);
    send_beat(OP_DATA, 8'h40);
    send_beat(OP_START, 8'h00);

    while (fed < 130) begin
      steady = (fed >= 45 && fed < 85);
      random_glyph();
      send_beat(OP_START, 8'($urandom));
      if (sb.active) begin
        total = sb.run_rows * sb.run_span;
        case ($urandom_range(0, 7))
          0: feed(total / 2);
          1: begin
            feed(total / 2);
            random_glyph();
            feed(total - total / 2);
          end
          default: feed(total);
        endcase
      end
      if ($urandom_range(0, 3) == 0) feed($urandom_range(1, 2));
    end
    steady = 0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
